// ===== rtl/u8cp_pkg.sv =====
// Shared types, constants and the code point map for the UTF-8 to codepage converter.
package u8cp_pkg;

   localparam longint unsigned MAX_OUT_LEN = 64'd65535;
   localparam int COUNT_W = 16;
   localparam logic [COUNT_W-1:0] COUNT_CAP =
      (MAX_OUT_LEN < 64'd65535) ? COUNT_W'(MAX_OUT_LEN) : COUNT_W'(65535);

   localparam int CP_W = 31;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CP_W-1:0] ARABIC_OFFSET = CP_W'(1376);
   localparam logic [CP_W-1:0] AR_LO1 = CP_W'(16'h0621);
   localparam logic [CP_W-1:0] AR_HI1 = CP_W'(16'h063A);
   localparam logic [CP_W-1:0] AR_LO2 = CP_W'(16'h0640);
   localparam logic [CP_W-1:0] AR_HI2 = CP_W'(16'h0652);
   localparam logic [CP_W-1:0] AR_COMMA = CP_W'(16'h060C);
   localparam logic [CP_W-1:0] AR_SEMICOLON = CP_W'(16'h061B);
   localparam logic [CP_W-1:0] AR_QUESTION = CP_W'(16'h061F);
   localparam logic [CP_W-1:0] CP_NBSP = CP_W'(16'h00A0);
   localparam logic [CP_W-1:0] CP_CURRENCY = CP_W'(16'h00A4);
   localparam logic [CP_W-1:0] CP_SOFT_HYPHEN = CP_W'(16'h00AD);

   localparam int LAT_ENTRIES = 29;
   localparam logic [15:0] LAT_CODE [LAT_ENTRIES] = '{
      16'h0627, 16'h0628, 16'h062A, 16'h062B, 16'h062C, 16'h062D, 16'h062E, 16'h062F,
      16'h0630, 16'h0631, 16'h0632, 16'h0633, 16'h0634, 16'h0635, 16'h0636, 16'h0637,
      16'h0638, 16'h0639, 16'h063A, 16'h0641, 16'h0642, 16'h0643, 16'h0644, 16'h0645,
      16'h0646, 16'h0648, 16'h0647, 16'h0649, 16'h064A
   };
   localparam logic [7:0] LAT_BYTE [LAT_ENTRIES] = '{
      8'hB0, 8'hB3, 8'hB7, 8'hB9, 8'hBA, 8'hBE, 8'hC0, 8'hC2,
      8'hC3, 8'hC4, 8'hC5, 8'hC7, 8'hC9, 8'hCB, 8'hCD, 8'hCF,
      8'hD0, 8'hD1, 8'hD5, 8'hD9, 8'hDB, 8'hDD, 8'hE1, 8'hE4,
      8'hE6, 8'hE8, 8'hE9, 8'hED, 8'hEE
   };

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic               is_terminator;
      logic [COUNT_W-1:0] string_length;
   } rsp_payload_type;

   // One decoded event from the front end.
   typedef struct packed {
      logic [CP_W-1:0] cp;
      logic            has_cp;
      logic            ascii;
      logic            last;
   } event_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] value;
   } map_result_type;

   function automatic map_result_type map_cp(input logic [CP_W-1:0] cp,
                                             input logic ascii,
                                             input logic arabic_mode);
      map_result_type r;
      logic [CP_W-1:0] diff;
      r.valid = 1'b0;
      r.value = 8'h00;
      diff = cp - ARABIC_OFFSET;
      if (ascii) begin
         r.valid = 1'b1;
         r.value = cp[7:0];
      end else if (arabic_mode) begin
         if (cp < CP_W'(127)) begin
            r.valid = 1'b1;
            r.value = cp[7:0];
         end else if ((cp >= AR_LO1 && cp <= AR_HI1) || (cp >= AR_LO2 && cp <= AR_HI2)) begin
            r.valid = 1'b1;
            r.value = diff[7:0];
         end else if (cp == CP_NBSP) begin
            r.valid = 1'b1;
            r.value = 8'hA0;
         end else if (cp == CP_CURRENCY) begin
            r.valid = 1'b1;
            r.value = 8'hA4;
         end else if (cp == AR_COMMA) begin
            r.valid = 1'b1;
            r.value = 8'hAC;
         end else if (cp == CP_SOFT_HYPHEN) begin
            r.valid = 1'b1;
            r.value = 8'hAD;
         end else if (cp == AR_SEMICOLON) begin
            r.valid = 1'b1;
            r.value = 8'hBB;
         end else if (cp == AR_QUESTION) begin
            r.valid = 1'b1;
            r.value = 8'hBF;
         end
      end else begin
         if (cp < CP_W'(256)) begin
            r.valid = 1'b1;
            r.value = cp[7:0];
         end else begin
            // Table codes are distinct, so at most one entry matches.
            for (int k = 0; k < LAT_ENTRIES; k++) begin
               if (cp == CP_W'(LAT_CODE[k])) begin
                  r.valid = 1'b1;
                  r.value = LAT_BYTE[k];
               end
            end
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/utf8_to_single_byte_codepage.sv =====
// Top level of the UTF-8 to single-byte codepage converter.
// The converter takes one UTF-8 byte per cycle on the req channel and returns codepage bytes
// on the rsp channel, followed by a NUL terminator carrying the string length after the byte
// marked last. A decoder accepts bytes and assembles code points, a four-entry event queue
// decouples it from the map stage, and the map stage writes one result per cycle into a
// single output register while that register is free. Bytes are accepted at one per cycle
// while the queue has room; an item that yields both a byte and the terminator holds the map
// stage until both have gone out, so the sustained rate is one item per cycle except for that
// case and output stalls. An item is registered in the queue, then its result in the output
// register. The csr channel writes map_select (1 selects the Arabic map, 0 the Latin-1 map);
// it resets to 1 and should be changed only while no item is in flight.
module utf8_to_single_byte_codepage
   import u8cp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_data
);

   logic      map_select_ff, map_select_in;
   logic      accept;
   logic      push_valid;
   event_type push_data;
   logic      full;
   logic      pop;
   logic      head_valid;
   event_type head_data;

   assign req_ready = ~full;
   assign accept = req_valid & req_ready;
   assign csr_ready = 1'b1;
   assign map_select_in = (csr_valid & csr_ready) ? csr_data : map_select_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_select_ff <= 1'b1;
      end else begin
         map_select_ff <= map_select_in;
      end
   end

   u8cp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   u8cp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   u8cp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .arabic_mode (map_select_ff),
      .head_valid  (head_valid),
      .head_data   (head_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== rtl/u8cp_front.sv =====
// Front end: UTF-8 sequence decoder that turns accepted bytes into events.
module u8cp_front
   import u8cp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_payload_type req_data,
   output logic            push_valid,
   output event_type       push_data
);

   logic [2:0]      remaining_ff, remaining_in;
   logic [CP_W-1:0] accum_ff, accum_in;
   logic            cont_ok_ff, cont_ok_in;

   logic [7:0]      b;
   logic [2:0]      rem_dec;
   logic            ok_next;
   logic [CP_W-1:0] acc_next;

   assign b = req_data.in_byte;
   assign rem_dec = remaining_ff - 3'd1;
   assign ok_next = cont_ok_ff & (b[7:6] == 2'b10);
   assign acc_next = {accum_ff[CP_W-7:0], b[5:0]};

   always_comb begin
      remaining_in = remaining_ff;
      accum_in = accum_ff;
      cont_ok_in = cont_ok_ff;
      push_data.cp = {{(CP_W-8){1'b0}}, b};
      push_data.has_cp = 1'b0;
      push_data.ascii = 1'b0;
      push_data.last = req_data.last_byte;
      if (accept) begin
         if (remaining_ff == 3'd0) begin
            priority if (b[7] == 1'b0) begin
               push_data.has_cp = 1'b1;
               push_data.ascii = 1'b1;
            end else if (b[7:6] == 2'b10) begin
               // A stray continuation byte is dropped.
            end else if (b[7:5] == 3'b110) begin
               remaining_in = 3'd1;
               accum_in = CP_W'(b[4:0]);
               cont_ok_in = 1'b1;
            end else if (b[7:4] == 4'b1110) begin
               remaining_in = 3'd2;
               accum_in = CP_W'(b[3:0]);
               cont_ok_in = 1'b1;
            end else if (b[7:3] == 5'b11110) begin
               remaining_in = 3'd3;
               accum_in = CP_W'(b[2:0]);
               cont_ok_in = 1'b1;
            end else if (b[7:2] == 6'b111110) begin
               remaining_in = 3'd4;
               accum_in = CP_W'(b[1:0]);
               cont_ok_in = 1'b1;
            end else if (b[7:1] == 7'b1111110) begin
               remaining_in = 3'd5;
               accum_in = CP_W'(b[0]);
               cont_ok_in = 1'b1;
            end else begin
               // The bytes 0xFE and 0xFF never start a sequence.
            end
         end else begin
            remaining_in = rem_dec;
            accum_in = acc_next;
            cont_ok_in = ok_next;
            if (rem_dec == 3'd0) begin
               push_data.cp = acc_next;
               push_data.has_cp = ok_next;
               accum_in = '0;
               cont_ok_in = 1'b1;
            end
         end
         // The last byte closes the string and drops any open sequence.
         if (req_data.last_byte) begin
            remaining_in = 3'd0;
            accum_in = '0;
            cont_ok_in = 1'b1;
         end
      end
   end

   assign push_valid = accept & (push_data.has_cp | push_data.last);

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 3'd0;
         accum_ff <= '0;
         cont_ok_ff <= 1'b1;
      end else begin
         remaining_ff <= remaining_in;
         accum_ff <= accum_in;
         cont_ok_ff <= cont_ok_in;
      end
   end

endmodule

// ===== rtl/u8cp_queue.sv =====
// Short event queue between the decoder and the map stage.
module u8cp_queue
   import u8cp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  event_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output event_type head_data
);

   event_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data = entry_ff[rd_ptr_ff];
   assign do_push = push_valid & ~full;
   assign do_pop = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10: count_in = count_ff + 1'b1;
         2'b01: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count exceeds its depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && full))
      else $error("event pushed into a full queue");

endmodule

// ===== rtl/u8cp_back.sv =====
// Back end: maps code points to codepage bytes, counts them and drives the result register.
module u8cp_back
   import u8cp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            arabic_mode,
   input  logic            head_valid,
   input  event_type       head_data,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               data_done_ff, data_done_in;

   map_result_type     mapped;
   logic               out_free;
   logic               emit_data;
   logic               load_term;

   assign mapped = map_cp(head_data.cp, head_data.ascii, arabic_mode);
   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign emit_data = head_data.has_cp & mapped.valid & ~data_done_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in = rsp_data_ff;
      count_in = count_ff;
      data_done_in = data_done_ff;
      pop = 1'b0;
      load_term = 1'b0;
      if (head_valid && out_free) begin
         priority if (emit_data) begin
            rsp_valid_in = 1'b1;
            rsp_data_in.out_byte = mapped.value;
            rsp_data_in.is_terminator = 1'b0;
            rsp_data_in.string_length = '0;
            if (count_ff < COUNT_CAP) begin
               count_in = count_ff + 1'b1;
            end
            // An event with both a byte and the end of string stays at the queue head until the terminator is loaded.
            if (head_data.last) begin
               data_done_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else if (head_data.last) begin
            load_term = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_data_in.out_byte = 8'h00;
            rsp_data_in.is_terminator = 1'b1;
            rsp_data_in.string_length = count_ff;
            count_in = '0;
            data_done_in = 1'b0;
            pop = 1'b1;
         end else begin
            // Unmapped code point: nothing goes out.
            pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
         data_done_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff <= count_in;
         data_done_ff <= data_done_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_done_only_on_last: assert property (@(posedge clock) disable iff (reset)
      data_done_ff |-> (head_valid && head_data.last))
      else $error("byte marked done without a pending end of string");

   a_count_clears_after_term: assert property (@(posedge clock) disable iff (reset)
      load_term |=> (count_ff == '0 && rsp_valid_ff && rsp_data_ff.is_terminator))
      else $error("count not cleared after terminator");

endmodule
